// ===== rtl/cafu_pkg.sv =====
// ----------------------------------------------------------------------------
// cafu_pkg: shared types and constants for the cpu alu and flag unit
// operation codes and status bit positions of the 8-bit execute unit
// ----------------------------------------------------------------------------
package cafu_pkg;

   typedef enum logic [4:0] {
      OP_ADC     = 5'd0,
      OP_AND     = 5'd1,
      OP_ORA     = 5'd2,
      OP_EOR     = 5'd3,
      OP_CMP     = 5'd4,
      OP_CPX     = 5'd5,
      OP_CPY     = 5'd6,
      OP_BIT     = 5'd7,
      OP_LDA     = 5'd8,
      OP_LDX     = 5'd9,
      OP_LDY     = 5'd10,
      OP_ASL_MEM = 5'd11,
      OP_LSR_MEM = 5'd12,
      OP_ROL_MEM = 5'd13,
      OP_ROR_MEM = 5'd14,
      OP_ASL_ACC = 5'd15,
      OP_LSR_ACC = 5'd16,
      OP_ROL_ACC = 5'd17,
      OP_ROR_ACC = 5'd18,
      OP_INC     = 5'd19,
      OP_DEC     = 5'd20,
      OP_INX     = 5'd21,
      OP_DEX     = 5'd22,
      OP_INY     = 5'd23,
      OP_DEY     = 5'd24,
      OP_CLC     = 5'd25,
      OP_SEC     = 5'd26,
      OP_CLD     = 5'd27,
      OP_SED     = 5'd28,
      OP_CLV     = 5'd29,
      OP_CLI     = 5'd30,
      OP_NOP     = 5'd31
   } op_type;

   // shifter function select
   typedef enum logic [1:0] {
      SH_ASL = 2'd0,
      SH_LSR = 2'd1,
      SH_ROL = 2'd2,
      SH_ROR = 2'd3
   } shift_type;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] STATUS_RESET = 8'h04;

endpackage

// ===== rtl/cpu_alu_flag_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit: 8-bit execute unit with register file and status flags
// binary add, logic ops, compares, bit test, loads, shifts, inc/dec, flag ops
// ----------------------------------------------------------------------------
//
// channel   dir   handshake              beat contents
// req_      in    req_valid/req_ready    op_select, operand_byte
// rsp_      out   rsp_valid/rsp_ready    store byte/valid, a, x, y, status
//
// one beat per cycle sustained unless the result side stalls; a beat is held in
// the input register and executed from there into the result register;
// execution only stalls when the result register is full and not being taken;
// the input register still takes a new beat whenever it empties in that cycle
// a, x, y and status update at the moment a beat moves into the result register
// reset clears a, x and y, sets status to 0x04 and empties both registers
//
module cpu_alu_flag_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_op_select,
   input  logic [7:0] req_operand_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_store_byte,
   output logic       rsp_store_valid,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_index_x_out,
   output logic [7:0] rsp_index_y_out,
   output logic [7:0] rsp_status_out
);

   // input register
   logic                in_valid_ff;
   cafu_pkg::op_type    in_op_ff;
   logic [7:0]          in_operand_ff;

   // architectural state
   logic [7:0]          acc_ff,    acc_in;
   logic [7:0]          x_ff,      x_in;
   logic [7:0]          y_ff,      y_in;
   logic [7:0]          status_ff, status_in;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          store_byte_ff, store_byte_in;
   logic                store_valid_ff, store_valid_in;

   logic                exec_fire;
   logic                req_fire;

   // the result register can take a beat when empty or being drained
   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   // shifter: returns {carry out, result}
   function automatic logic [8:0] shift_calc(input cafu_pkg::shift_type kind,
                                             input logic [7:0] v,
                                             input logic cin);
      logic [8:0] res;
      case (kind)
         cafu_pkg::SH_ASL: res = {v[7], v[6:0], 1'b0};
         cafu_pkg::SH_LSR: res = {v[0], 1'b0, v[7:1]};
         cafu_pkg::SH_ROL: res = {v[7], v[6:0], cin};
         cafu_pkg::SH_ROR: res = {v[0], cin, v[7:1]};
         default:          res = {1'b0, v};
      endcase
      return res;
   endfunction

   // execute datapath
   logic [8:0] add_sum;
   logic [7:0] cmp_reg;
   logic [8:0] cmp_diff;
   logic [8:0] shift_res;
   logic [7:0] shift_src;
   logic [7:0] zn_val;
   logic       zn_upd;

   always_comb begin
      add_sum = {1'b0, acc_ff} + {1'b0, in_operand_ff} + {8'd0, status_ff[cafu_pkg::FLAG_C]};

      // compare register select
      case (in_op_ff)
         cafu_pkg::OP_CPX: cmp_reg = x_ff;
         cafu_pkg::OP_CPY: cmp_reg = y_ff;
         default:          cmp_reg = acc_ff;
      endcase
      cmp_diff = {1'b0, cmp_reg} - {1'b0, in_operand_ff};

      // memory forms take the operand, accumulator forms take a
      case (in_op_ff)
         cafu_pkg::OP_ASL_ACC, cafu_pkg::OP_LSR_ACC,
         cafu_pkg::OP_ROL_ACC, cafu_pkg::OP_ROR_ACC: shift_src = acc_ff;
         default:                                    shift_src = in_operand_ff;
      endcase
      // each memory form shares its shift function with the accumulator form
      case (in_op_ff)
         cafu_pkg::OP_ASL_MEM, cafu_pkg::OP_ASL_ACC:
            shift_res = shift_calc(cafu_pkg::SH_ASL, shift_src, status_ff[cafu_pkg::FLAG_C]);
         cafu_pkg::OP_LSR_MEM, cafu_pkg::OP_LSR_ACC:
            shift_res = shift_calc(cafu_pkg::SH_LSR, shift_src, status_ff[cafu_pkg::FLAG_C]);
         cafu_pkg::OP_ROL_MEM, cafu_pkg::OP_ROL_ACC:
            shift_res = shift_calc(cafu_pkg::SH_ROL, shift_src, status_ff[cafu_pkg::FLAG_C]);
         default:
            shift_res = shift_calc(cafu_pkg::SH_ROR, shift_src, status_ff[cafu_pkg::FLAG_C]);
      endcase

      acc_in         = acc_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      status_in      = status_ff;
      store_byte_in  = 8'd0;
      store_valid_in = 1'b0;
      zn_val         = 8'd0;
      zn_upd         = 1'b0;

      case (in_op_ff)
         cafu_pkg::OP_ADC: begin
            acc_in                      = add_sum[7:0];
            status_in[cafu_pkg::FLAG_C] = add_sum[8];
            status_in[cafu_pkg::FLAG_V] = (acc_ff[7] == in_operand_ff[7])
                                          && (acc_ff[7] != add_sum[7]);
            zn_val = add_sum[7:0];
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_AND: begin
            acc_in = acc_ff & in_operand_ff;
            zn_val = acc_ff & in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_ORA: begin
            acc_in = acc_ff | in_operand_ff;
            zn_val = acc_ff | in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_EOR: begin
            acc_in = acc_ff ^ in_operand_ff;
            zn_val = acc_ff ^ in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_CMP, cafu_pkg::OP_CPX, cafu_pkg::OP_CPY: begin
            status_in[cafu_pkg::FLAG_C] = !cmp_diff[8];
            status_in[cafu_pkg::FLAG_Z] = (cmp_reg == in_operand_ff);
            status_in[cafu_pkg::FLAG_N] = cmp_diff[7];
         end
         cafu_pkg::OP_BIT: begin
            status_in[cafu_pkg::FLAG_Z] = ((acc_ff & in_operand_ff) == 8'd0);
            status_in[cafu_pkg::FLAG_N] = in_operand_ff[7];
            status_in[cafu_pkg::FLAG_V] = in_operand_ff[6];
         end
         cafu_pkg::OP_LDA: begin
            acc_in = in_operand_ff;
            zn_val = in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_LDX: begin
            x_in   = in_operand_ff;
            zn_val = in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_LDY: begin
            y_in   = in_operand_ff;
            zn_val = in_operand_ff;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_ASL_MEM, cafu_pkg::OP_LSR_MEM,
         cafu_pkg::OP_ROL_MEM, cafu_pkg::OP_ROR_MEM: begin
            store_byte_in               = shift_res[7:0];
            store_valid_in              = 1'b1;
            status_in[cafu_pkg::FLAG_C] = shift_res[8];
            zn_val = shift_res[7:0];
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_ASL_ACC, cafu_pkg::OP_LSR_ACC,
         cafu_pkg::OP_ROL_ACC, cafu_pkg::OP_ROR_ACC: begin
            acc_in                      = shift_res[7:0];
            status_in[cafu_pkg::FLAG_C] = shift_res[8];
            zn_val = shift_res[7:0];
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_INC: begin
            store_byte_in  = in_operand_ff + 8'd1;
            store_valid_in = 1'b1;
            zn_val = in_operand_ff + 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_DEC: begin
            store_byte_in  = in_operand_ff - 8'd1;
            store_valid_in = 1'b1;
            zn_val = in_operand_ff - 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_INX: begin
            x_in   = x_ff + 8'd1;
            zn_val = x_ff + 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_DEX: begin
            x_in   = x_ff - 8'd1;
            zn_val = x_ff - 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_INY: begin
            y_in   = y_ff + 8'd1;
            zn_val = y_ff + 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_DEY: begin
            y_in   = y_ff - 8'd1;
            zn_val = y_ff - 8'd1;
            zn_upd = 1'b1;
         end
         cafu_pkg::OP_CLC: status_in[cafu_pkg::FLAG_C] = 1'b0;
         cafu_pkg::OP_SEC: status_in[cafu_pkg::FLAG_C] = 1'b1;
         cafu_pkg::OP_CLD: status_in[cafu_pkg::FLAG_D] = 1'b0;
         cafu_pkg::OP_SED: status_in[cafu_pkg::FLAG_D] = 1'b1;
         cafu_pkg::OP_CLV: status_in[cafu_pkg::FLAG_V] = 1'b0;
         cafu_pkg::OP_CLI: status_in[cafu_pkg::FLAG_I] = 1'b0;
         default: begin
            // no operation
         end
      endcase

      // common zero / negative update
      if (zn_upd) begin
         status_in[cafu_pkg::FLAG_Z] = (zn_val == 8'd0);
         status_in[cafu_pkg::FLAG_N] = zn_val[7];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         x_ff         <= 8'd0;
         y_ff         <= 8'd0;
         status_ff    <= cafu_pkg::STATUS_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
            x_ff         <= x_in;
            y_ff         <= y_in;
            status_ff    <= status_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff      <= cafu_pkg::op_type'(req_op_select);
         in_operand_ff <= req_operand_byte;
      end
      if (exec_fire) begin
         store_byte_ff  <= store_byte_in;
         store_valid_ff <= store_valid_in;
      end
   end

   // the register file doubles as the result payload
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_store_byte  = store_byte_ff;
   assign rsp_store_valid = store_valid_ff;
   assign rsp_acc_out     = acc_ff;
   assign rsp_index_x_out = x_ff;
   assign rsp_index_y_out = y_ff;
   assign rsp_status_out  = status_ff;

   // a waiting beat moves on whenever the result register frees up
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("pending beat not executed");

   // store byte is zero unless a write-back is requested
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !store_valid_ff |-> store_byte_ff == 8'd0)
      else $error("store byte nonzero without write-back");

   // break and unused bits never set
   assert property (@(posedge clock) disable iff (reset)
      status_ff[5:4] == 2'b00)
      else $error("reserved status bits changed");

   // interrupt disable only clears through cli
   assert property (@(posedge clock) disable iff (reset)
      $fell(status_ff[cafu_pkg::FLAG_I]) |->
         $past(exec_fire) && $past(in_op_ff) == cafu_pkg::OP_CLI)
      else $error("interrupt disable cleared without cli");

   // registers hold while no beat executes
   assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(acc_ff) && $stable(x_ff) && $stable(y_ff) && $stable(status_ff))
      else $error("state changed without execution");

endmodule

// ===== verif/cpu_alu_flag_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit_tb: self-checking bench for the 8-bit execute unit
// table of directed beats, then random beats under three throttle mixes, all results
// checked in order against typed-in rows or an in-bench model of registers and flags
// ----------------------------------------------------------------------------
module cpu_alu_flag_unit_tb;

   // one result beat, packed in port order
   typedef struct packed {
      logic [7:0] store_byte;
      logic       store_valid;
      logic [7:0] acc;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] status;
   } alu_result_type;

   // directed row: result typed in only where known is set
   typedef struct {
      cafu_pkg::op_type op;
      logic [7:0]       operand;
      bit               known;
      alu_result_type   result;
   } table_row_type;

   localparam int RANDOM_PER_PHASE = 240;
   localparam int HOLD_AT          = 560;   // beats sent before the long result stall
   localparam int HOLD_CYCLES      = 60;
   localparam int DRAIN_CYCLES     = 8;     // latency plus margin
   localparam int STALL_LIMIT      = 2000;  // cycles with no beat moving on either side

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [4:0] req_op_select    = 5'd0;
   logic [7:0] req_operand_byte = 8'h00;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_store_byte;
   logic       rsp_store_valid;
   logic [7:0] rsp_acc_out;
   logic [7:0] rsp_index_x_out;
   logic [7:0] rsp_index_y_out;
   logic [7:0] rsp_status_out;

   // model state, mirrors the block's a, x, y and status
   logic [7:0] acc_q   = 8'h00;
   logic [7:0] x_q     = 8'h00;
   logic [7:0] y_q     = 8'h00;
   logic [7:0] flags_q = cafu_pkg::STATUS_RESET;

   alu_result_type pending_results[$];
   table_row_type  stim_table[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent    = 0;
   int results_seen  = 0;
   int write_backs   = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   bit op_seen[32];

   cpu_alu_flag_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op_select    (req_op_select),
      .req_operand_byte (req_operand_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_store_byte   (rsp_store_byte),
      .rsp_store_valid  (rsp_store_valid),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_index_x_out  (rsp_index_x_out),
      .rsp_index_y_out  (rsp_index_y_out),
      .rsp_status_out   (rsp_status_out)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // model: apply one operation to the mirrored registers, return the result beat
   // ---------------------------------------------------------------------------
   function alu_result_type execute_op(input cafu_pkg::op_type op, input logic [7:0] m);
      alu_result_type      r;
      logic [8:0]          sum;
      logic [7:0]          v;
      logic [7:0]          src;
      logic [7:0]          cmp_val;
      logic [4:0]          sel;
      cafu_pkg::shift_type kind;
      logic                cin;
      logic                zn;
      r   = '0;
      v   = 8'h00;
      zn  = 1'b0;
      cin = flags_q[cafu_pkg::FLAG_C];
      case (op)
         cafu_pkg::OP_ADC: begin
            sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, cin};
            v   = sum[7:0];
            flags_q[cafu_pkg::FLAG_C] = sum[8];
            // overflow: operands agree in sign, sum does not
            flags_q[cafu_pkg::FLAG_V] = (acc_q[7] == m[7]) && (v[7] != acc_q[7]);
            acc_q = v;
            zn    = 1'b1;
         end
         cafu_pkg::OP_AND: begin
            v = acc_q & m; acc_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_ORA: begin
            v = acc_q | m; acc_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_EOR: begin
            v = acc_q ^ m; acc_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_CMP, cafu_pkg::OP_CPX, cafu_pkg::OP_CPY: begin
            cmp_val = (op == cafu_pkg::OP_CMP) ? acc_q :
                      (op == cafu_pkg::OP_CPX) ? x_q : y_q;
            v = cmp_val - m;
            flags_q[cafu_pkg::FLAG_C] = cmp_val >= m;
            flags_q[cafu_pkg::FLAG_Z] = cmp_val == m;
            flags_q[cafu_pkg::FLAG_N] = v[7];
         end
         cafu_pkg::OP_BIT: begin
            // n and v come straight from the operand
            flags_q[cafu_pkg::FLAG_Z] = (acc_q & m) == 8'h00;
            flags_q[cafu_pkg::FLAG_N] = m[7];
            flags_q[cafu_pkg::FLAG_V] = m[6];
         end
         cafu_pkg::OP_LDA: begin
            v = m; acc_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_LDX: begin
            v = m; x_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_LDY: begin
            v = m; y_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_ASL_MEM, cafu_pkg::OP_LSR_MEM, cafu_pkg::OP_ROL_MEM,
         cafu_pkg::OP_ROR_MEM, cafu_pkg::OP_ASL_ACC, cafu_pkg::OP_LSR_ACC,
         cafu_pkg::OP_ROL_ACC, cafu_pkg::OP_ROR_ACC: begin
            if (op <= cafu_pkg::OP_ROR_MEM) begin
               src = m;
               sel = op - cafu_pkg::OP_ASL_MEM;
            end else begin
               src = acc_q;
               sel = op - cafu_pkg::OP_ASL_ACC;
            end
            kind = cafu_pkg::shift_type'(sel[1:0]);
            case (kind)
               cafu_pkg::SH_ASL: begin
                  flags_q[cafu_pkg::FLAG_C] = src[7]; v = {src[6:0], 1'b0};
               end
               cafu_pkg::SH_LSR: begin
                  flags_q[cafu_pkg::FLAG_C] = src[0]; v = {1'b0, src[7:1]};
               end
               cafu_pkg::SH_ROL: begin
                  flags_q[cafu_pkg::FLAG_C] = src[7]; v = {src[6:0], cin};
               end
               default: begin
                  flags_q[cafu_pkg::FLAG_C] = src[0]; v = {cin, src[7:1]};
               end
            endcase
            if (op <= cafu_pkg::OP_ROR_MEM) begin
               r.store_byte  = v;
               r.store_valid = 1'b1;
            end else begin
               acc_q = v;
            end
            zn = 1'b1;
         end
         cafu_pkg::OP_INC: begin
            v = m + 8'h01; r.store_byte = v; r.store_valid = 1'b1; zn = 1'b1;
         end
         cafu_pkg::OP_DEC: begin
            v = m - 8'h01; r.store_byte = v; r.store_valid = 1'b1; zn = 1'b1;
         end
         cafu_pkg::OP_INX: begin
            v = x_q + 8'h01; x_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_DEX: begin
            v = x_q - 8'h01; x_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_INY: begin
            v = y_q + 8'h01; y_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_DEY: begin
            v = y_q - 8'h01; y_q = v; zn = 1'b1;
         end
         cafu_pkg::OP_CLC: flags_q[cafu_pkg::FLAG_C] = 1'b0;
         cafu_pkg::OP_SEC: flags_q[cafu_pkg::FLAG_C] = 1'b1;
         cafu_pkg::OP_CLD: flags_q[cafu_pkg::FLAG_D] = 1'b0;
         cafu_pkg::OP_SED: flags_q[cafu_pkg::FLAG_D] = 1'b1;
         cafu_pkg::OP_CLV: flags_q[cafu_pkg::FLAG_V] = 1'b0;
         cafu_pkg::OP_CLI: flags_q[cafu_pkg::FLAG_I] = 1'b0;
         default: ;   // no operation leaves everything alone
      endcase
      if (zn) begin
         flags_q[cafu_pkg::FLAG_Z] = v == 8'h00;
         flags_q[cafu_pkg::FLAG_N] = v[7];
      end
      r.acc     = acc_q;
      r.index_x = x_q;
      r.index_y = y_q;
      r.status  = flags_q;
      return r;
   endfunction

   function void plan(input cafu_pkg::op_type op, input logic [7:0] m,
                      input bit known = 1'b0, input alu_result_type res = '0);
      table_row_type row;
      row.op      = op;
      row.operand = m;
      row.known   = known;
      row.result  = res;
      stim_table.push_back(row);
   endfunction

   // ---------------------------------------------------------------------------
   // request side: offer one beat, hold it until taken, then record the expected
   // result; valid is left high so back-to-back beats never drop it
   // ---------------------------------------------------------------------------
   task automatic send_beat(input cafu_pkg::op_type op, input logic [7:0] m,
                            input bit known = 1'b0, input alu_result_type res = '0);
      alu_result_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op_select    <= op;
      req_operand_byte <= m;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      predicted = execute_op(op, m);
      // typed-in rows override the model, the model still tracks the state
      pending_results.push_back(known ? res : predicted);
      op_seen[op] = 1'b1;
      beats_sent++;
   endtask

   function automatic logic [7:0] random_operand();
      logic [7:0] m;
      m = 8'($urandom_range(255));
      // lean on the corner values now and then
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(4))
            0: m = 8'h00;
            1: m = 8'h01;
            2: m = 8'h7f;
            3: m = 8'h80;
            default: m = 8'hff;
         endcase
      end
      return m;
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_beat(cafu_pkg::op_type'($urandom_range(31)), random_operand());
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus: reset, directed table, then three random phases
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int ops_hit;
      ops_hit = 0;

      // straight after reset: results that can be worked out by hand
      //            op                 operand      store  sv    a      x      y      p
      plan(cafu_pkg::OP_NOP, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h04});
      plan(cafu_pkg::OP_LDA, 8'hff, 1'b1, {8'h00, 1'b0, 8'hff, 8'h00, 8'h00, 8'h84});
      plan(cafu_pkg::OP_LDX, 8'h00, 1'b1, {8'h00, 1'b0, 8'hff, 8'h00, 8'h00, 8'h06});
      plan(cafu_pkg::OP_LDY, 8'h80, 1'b1, {8'h00, 1'b0, 8'hff, 8'h00, 8'h80, 8'h84});
      plan(cafu_pkg::OP_SEC, 8'h00, 1'b1, {8'h00, 1'b0, 8'hff, 8'h00, 8'h80, 8'h85});
      // increment and decrement wrap at the byte ends
      plan(cafu_pkg::OP_INC, 8'hff, 1'b1, {8'h00, 1'b1, 8'hff, 8'h00, 8'h80, 8'h07});
      plan(cafu_pkg::OP_DEC, 8'h00, 1'b1, {8'hff, 1'b1, 8'hff, 8'h00, 8'h80, 8'h85});
      // model-checked rows: carry in, signed overflow, logic ops, compares, bit test
      plan(cafu_pkg::OP_ADC, 8'h01);
      plan(cafu_pkg::OP_ADC, 8'h7f);
      plan(cafu_pkg::OP_AND, 8'h00);
      plan(cafu_pkg::OP_ORA, 8'hff);
      plan(cafu_pkg::OP_EOR, 8'haa);
      plan(cafu_pkg::OP_CMP, 8'h80);
      plan(cafu_pkg::OP_CPX, 8'hff);
      plan(cafu_pkg::OP_CPY, 8'h80);
      plan(cafu_pkg::OP_BIT, 8'hc0);
      plan(cafu_pkg::OP_BIT, 8'h3f);
      // shifts and rotates, memory then accumulator, then index inc/dec
      plan(cafu_pkg::OP_ASL_MEM, 8'h80);
      plan(cafu_pkg::OP_LSR_MEM, 8'h01);
      plan(cafu_pkg::OP_ROL_MEM, 8'hff);
      plan(cafu_pkg::OP_ROR_MEM, 8'h00);
      plan(cafu_pkg::OP_ASL_ACC, 8'h00);
      plan(cafu_pkg::OP_LSR_ACC, 8'h00);
      plan(cafu_pkg::OP_ROL_ACC, 8'h00);
      plan(cafu_pkg::OP_ROR_ACC, 8'h00);
      plan(cafu_pkg::OP_INX, 8'h00);
      plan(cafu_pkg::OP_DEX, 8'h00);
      plan(cafu_pkg::OP_INY, 8'h00);
      plan(cafu_pkg::OP_DEY, 8'h00);
      // flag ops; bit 4 and bit 5 must never move
      plan(cafu_pkg::OP_CLC, 8'h00);
      plan(cafu_pkg::OP_SED, 8'h00);
      plan(cafu_pkg::OP_CLD, 8'h00);
      plan(cafu_pkg::OP_CLV, 8'h00);
      plan(cafu_pkg::OP_CLI, 8'hff);
      plan(cafu_pkg::OP_NOP, 8'hff);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sender sparse-ish, receiver mostly stalled
      send_idle_pct = 34;
      recv_idle_pct = 87;
      foreach (stim_table[i]) begin
         send_beat(stim_table[i].op, stim_table[i].operand, stim_table[i].known,
                   stim_table[i].result);
      end
      send_random(RANDOM_PER_PHASE);

      // roles swapped
      send_idle_pct = 87;
      recv_idle_pct = 34;
      send_random(RANDOM_PER_PHASE);

      // sender pauses until the block has handed back everything
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      // full rate both sides; the long result stall lands in here
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      foreach (op_seen[i]) ops_hit += op_seen[i];
      $display("ran %0d beats (%0d from the table, rest random) under three throttle mixes,",
               beats_sent, stim_table.size());
      $display("%0d of 32 op codes, %0d write-back beats, one long result stall, one drain",
               ops_hit, write_backs);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d result beats wrong or unexpected", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // result side: check every taken beat against the oldest expectation, then
   // pick next cycle's ready; one long hold-off once the sender is far enough in
   // ---------------------------------------------------------------------------
   initial begin : result_side
      int             hold_left;
      bit             hold_done;
      alu_result_type got;
      alu_result_type want;
      hold_left = 0;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_store_byte, rsp_store_valid, rsp_acc_out, rsp_index_x_out,
                   rsp_index_y_out, rsp_status_out};
            results_seen++;
            if (rsp_store_valid) write_backs++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat %0d arrived with nothing expected: %h", results_seen,
                           got);
            end else begin
               want = pending_results.pop_front();
               if (got.store_byte !== want.store_byte || got.store_valid !== want.store_valid ||
                   got.acc !== want.acc || got.index_x !== want.index_x ||
                   got.index_y !== want.index_y || got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result beat %0d: want st=%h/%b a=%h x=%h y=%h p=%h",
                              results_seen, want.store_byte, want.store_valid, want.acc,
                              want.index_x, want.index_y, want.status);
                     $display("result beat %0d: got  st=%h/%b a=%h x=%h y=%h p=%h",
                              results_seen, got.store_byte, got.store_valid, got.acc,
                              got.index_x, got.index_y, got.status);
                  end
               end
            end
         end
         if (!hold_done && beats_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            // block fills up and must push back on the request side
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog: too long without a beat moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d results still owed", stall_cycles,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule
